// ===== rtl/core/fifo_with_move_to_tail_macros.svh =====
// ----------------------------------------------------------------------------
// fifo_with_move_to_tail_macros.svh
// Assertion shorthands for the move-to-tail FIFO. They sample on clk and
// are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_MOVE_TO_TAIL_MACROS_SVH
`define FIFO_WITH_MOVE_TO_TAIL_MACROS_SVH

// Same-cycle implication
`define FWMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fwmt assertion failed");

// Next-cycle implication
`define FWMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fwmt assertion failed");

`endif

// ===== rtl/core/fwmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fwmt_pkg
// Shared sizes and codes of the move-to-tail FIFO.
// ----------------------------------------------------------------------------
package fwmt_pkg;

	// Storage geometry
	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Transaction field widths
	localparam int OP_W      = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;
	localparam int LIMIT_W   = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

	// Operation codes
	localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/core/fwmt_req_if.sv =====
// ----------------------------------------------------------------------------
// fwmt_req_if
// Request channel: operation and value with valid/ready.
// ----------------------------------------------------------------------------
interface fwmt_req_if import fwmt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== rtl/core/fwmt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fwmt_rsp_if
// Response channel: status, data, occupancy and flags with valid/ready.
// ----------------------------------------------------------------------------
interface fwmt_rsp_if import fwmt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  data;
	logic [OCC_W-1:0]    occupancy;
	logic                is_empty;
	logic                is_full;

	modport source (output valid, output status, output data, output occupancy,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input status, input data, input occupancy,
		input is_empty, input is_full, output ready);
endinterface

// ===== rtl/core/fifo_with_move_to_tail.sv =====
// ----------------------------------------------------------------------------
// fifo_with_move_to_tail
// Circular word FIFO with programmable limit and a move-to-tail operation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction: enqueue, dequeue or move-to-tail with a
//   value. rsp returns one transaction per request: status, dequeued data,
//   occupancy after the operation, and empty/full flags.
//   cfg_we/cfg_wdata set the slot limit (0 acts as 1, above 16 acts as 16)
//   and empty the queue; write only while the block is idle.
// Sequencing:
//   Enqueue, dequeue and the unused code go from S_IDLE to S_FIN, where the
//   response is registered once the output register is free; a new request
//   is taken only back in S_IDLE. Move-to-tail compares entries from the head,
//   moves each later entry up one slot and writes the value to the last slot.
// Reset:
//   Indices and count clear, limit returns to 16; stored words are not
//   cleared (no entry is read before it is written).
// Back-pressure:
//   The response sits in an output register; a request is still accepted
//   while rsp is stalled, and the block then holds its next response until
//   the register frees.
// ----------------------------------------------------------------------------
module fifo_with_move_to_tail import fwmt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	fwmt_req_if.sink           req,
	fwmt_rsp_if.source         rsp
);

	`include "fifo_with_move_to_tail_macros.svh"

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SRCH_RD  = 3'd1;
	localparam logic [2:0] S_SRCH_CMP = 3'd2;
	localparam logic [2:0] S_SH_RD    = 3'd3;
	localparam logic [2:0] S_SH_WR    = 3'd4;
	localparam logic [2:0] S_FIN      = 3'd5;

	logic [2:0]           state_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [IDX_W-1:0]     wr_idx_q;
	logic [CNT_W-1:0]     occ_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     pos_q;
	logic [STATUS_W-1:0]  st_q;
	logic                 deq_ok_q;
	logic [WORD_BITS-1:0] val_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [VALUE_W-1:0]   out_data_q;
	logic [OCC_W-1:0]     out_occ_q;
	logic                 out_empty_q;
	logic                 out_full_q;

	// Entry memory
	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] mem_rdata_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [IDX_W-1:0]     mem_waddr;
	logic [IDX_W-1:0]     mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic [CNT_W-1:0]     lim;
	logic                 req_fire;
	logic                 is_full_now;
	logic                 is_empty_now;
	logic                 pos_last;
	logic                 out_free;
	logic [IDX_W-1:0]     ptr_next;

	// Wrap an index at the effective limit
	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx,
		input logic [CNT_W-1:0] lim_v);
		logic [CNT_W-1:0] inc;
		inc = CNT_W'(idx) + CNT_W'(1);
		return (inc >= lim_v) ? '0 : inc[IDX_W-1:0];
	endfunction

	// Effective limit and flags
	always_comb begin
		if (limit_q == '0) begin
			lim = CNT_W'(1);
		end else if (int'(limit_q) > DEPTH) begin
			lim = CNT_W'(DEPTH);
		end else begin
			lim = CNT_W'(limit_q);
		end
	end

	assign is_full_now  = (occ_q >= lim);
	assign is_empty_now = (occ_q == '0);
	assign pos_last     = ((CNT_W'(pos_q) + CNT_W'(1)) == occ_q);
	assign ptr_next     = idx_next(ptr_q, lim);
	assign out_free     = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	// Memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ptr_q;
		mem_raddr = ptr_q;
		mem_wdata = val_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire && req.operation == OP_ENQ && !is_full_now) begin
					mem_we    = 1'b1;
					mem_waddr = wr_idx_q;
					mem_wdata = req.value[WORD_BITS-1:0];
				end
				if (req_fire && req.operation == OP_DEQ && !is_empty_now) begin
					mem_re    = 1'b1;
					mem_raddr = rd_idx_q;
				end
			end
			S_SRCH_RD: begin
				mem_re = 1'b1;
			end
			S_SH_RD: begin
				// last held slot takes the moved value, else fetch the successor
				if (pos_last) begin
					mem_we = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_next;
				end
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// Sequencer and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RESET;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			occ_q       <= '0;
			ptr_q       <= '0;
			pos_q       <= '0;
			st_q        <= ST_OK;
			deq_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && !(state_q == S_FIN && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						case (req.operation)
							OP_ENQ: begin
								deq_ok_q <= 1'b0;
								state_q  <= S_FIN;
								if (is_full_now) begin
									st_q <= ST_FULL;
								end else begin
									st_q     <= ST_OK;
									wr_idx_q <= idx_next(wr_idx_q, lim);
									occ_q    <= occ_q + CNT_W'(1);
								end
							end
							OP_DEQ: begin
								state_q <= S_FIN;
								if (is_empty_now) begin
									st_q     <= ST_EMPTY;
									deq_ok_q <= 1'b0;
								end else begin
									st_q     <= ST_OK;
									rd_idx_q <= idx_next(rd_idx_q, lim);
									occ_q    <= occ_q - CNT_W'(1);
									deq_ok_q <= 1'b1;
								end
							end
							OP_MOVE: begin
								deq_ok_q <= 1'b0;
								if (is_empty_now) begin
									st_q    <= ST_NOT_FOUND;
									state_q <= S_FIN;
								end else begin
									st_q    <= ST_OK;
									ptr_q   <= rd_idx_q;
									pos_q   <= '0;
									state_q <= S_SRCH_RD;
								end
							end
							default: begin
								st_q     <= ST_OK;
								deq_ok_q <= 1'b0;
								state_q  <= S_FIN;
							end
						endcase
					end else if (cfg_we) begin
						limit_q  <= cfg_wdata;
						rd_idx_q <= '0;
						wr_idx_q <= '0;
						occ_q    <= '0;
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (mem_rdata_q == val_q) begin
						state_q <= S_SH_RD;
					end else if (pos_last) begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_FIN;
					end else begin
						ptr_q   <= ptr_next;
						pos_q   <= pos_q + IDX_W'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SH_RD: begin
					state_q <= pos_last ? S_FIN : S_SH_WR;
				end
				S_SH_WR: begin
					ptr_q   <= ptr_next;
					pos_q   <= pos_q + IDX_W'(1);
					state_q <= S_SH_RD;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Move value and response payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			val_q <= req.value[WORD_BITS-1:0];
		end
		if (state_q == S_FIN && out_free) begin
			out_status_q <= st_q;
			out_data_q   <= deq_ok_q ? VALUE_W'(mem_rdata_q) : '0;
			out_occ_q    <= OCC_W'(occ_q);
			out_empty_q  <= is_empty_now;
			out_full_q   <= (occ_q == lim);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.data      = out_data_q;
	assign rsp.occupancy = out_occ_q;
	assign rsp.is_empty  = out_empty_q;
	assign rsp.is_full   = out_full_q;

	// Checks
	`FWMT_ASSERT_NOW(a_occ_within_limit, 1'b1, occ_q <= lim)
	`FWMT_ASSERT_NOW(a_walk_in_range, (state_q == S_SRCH_CMP || state_q == S_SH_WR), CNT_W'(pos_q) < occ_q)
	`FWMT_ASSERT_NOW(a_no_rw_same_entry, mem_we && mem_re, mem_waddr != mem_raddr)
	`FWMT_ASSERT_NEXT(a_enq_counts, req_fire && req.operation == OP_ENQ && !is_full_now, occ_q == $past(occ_q) + CNT_W'(1))

endmodule
